>>> hdl/segregated_free_list_macros.svh
// Assertion macros for the segregated free list top level.
// No dependencies; the asserting module provides i_clk and i_rst_n.
`ifndef SEGREGATED_FREE_LIST_MACROS_SVH
`define SEGREGATED_FREE_LIST_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sfl_pkg.sv
// Shared types, widths and codes for the segregated free list.
// No dependencies; used by sfl_cfg, the top level and the testbench.
`default_nettype none

package sfl_pkg;

    // Default sizing of the block.
    localparam int NUM_BINS_DEF   = 8;
    localparam int NUM_BLOCKS_DEF = 1024;

    // Fixed field widths of the request and response channels.
    localparam int OP_W      = 1;
    localparam int BIN_SEL_W = 3;
    localparam int BLOCK_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int SUM_W     = 27;

    // Block size registers.
    localparam int SIZE_W    = 17;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
    localparam logic [OP_W-1:0] OP_POP  = 1'b1;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    // One configuration write as seen by the size register file.
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] index;
        logic [SIZE_W-1:0]    data;
    } t_cfg_wr;

    // Reset block size of a bin: 16 bytes doubled once per bin.
    function automatic logic [SIZE_W-1:0] size_reset(input logic [REG_IDX_W-1:0] idx);
        logic [SIZE_W-1:0] base;
        base = SIZE_W'(16);
        return base << idx;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sfl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the next-link chain of the free lists.
`default_nettype none

module sfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/sfl_cfg.sv
// Block size register file of the segregated free list, one register per bin.
// Depends on sfl_pkg for widths, reset values and the write struct.
`default_nettype none

module sfl_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sfl_pkg::t_cfg_wr                i_wr,
    input  wire logic [sfl_pkg::REG_IDX_W-1:0]   i_rd_sel,
    output logic      [sfl_pkg::SIZE_W-1:0]      o_size
);

    localparam int REG_COUNT = sfl_pkg::REG_COUNT;
    localparam int REG_IDX_W = sfl_pkg::REG_IDX_W;
    localparam int SIZE_W    = sfl_pkg::SIZE_W;

    logic [SIZE_W-1:0] r_size [REG_COUNT];

    // Registers load their reset sizes and then take writes by index.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < REG_COUNT; i++) begin
            if (!i_rst_n) begin
                r_size[i] <= sfl_pkg::size_reset(REG_IDX_W'(i));
            end else if (i_wr.we && (i_wr.index == REG_IDX_W'(i))) begin
                r_size[i] <= i_wr.data;
            end
        end
    end

    // Size of the selected bin.
    assign o_size = r_size[i_rd_sel];

endmodule

`default_nettype wire

>>> hdl/segregated_free_list.sv
// Top level of the segregated free list: controller, bin heads and counts.
// Depends on sfl_pkg, sfl_ram, sfl_cfg and segregated_free_list_macros.svh.
//
// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready) with an
// operation, a bin and, for a push, a block index. Each request produces
// exactly one response on the output channel (o_out_valid / i_out_ready)
// with the popped block, a status, the bin's count and the idle byte total.
// A push, a rejected push and a pop on an empty bin answer in the cycle after
// the transfer. A pop that finds a block reads the next link from the link RAM
// and answers from S_POP once it returns. Pushes are taken at one request every
// cycle while the receiver takes each response; no request is taken while a
// pop is in S_POP. The response sits in an output register: a new request is
// taken in the cycle that the waiting response is transferred. When the receiver
// stalls, the response holds and no request is taken. Reset clears all bin counts
// and the idle total and loads the default bin sizes; there is no clearing pass.
// Size registers are written through i_cfg_we / i_cfg_index / i_cfg_data by the
// user only while no request is in flight; the block does not enforce it.
`default_nettype none

`include "segregated_free_list_macros.svh"

module segregated_free_list #(
    parameter int NUM_BINS   = sfl_pkg::NUM_BINS_DEF,
    parameter int NUM_BLOCKS = sfl_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration writes.
    input  wire logic                            i_cfg_we,
    input  wire logic [sfl_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sfl_pkg::SIZE_W-1:0]      i_cfg_data,
    // Request channel.
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [sfl_pkg::OP_W-1:0]        i_operation,
    input  wire logic [sfl_pkg::BIN_SEL_W-1:0]   i_bin_sel,
    input  wire logic [sfl_pkg::BLOCK_W-1:0]     i_block_in,
    // Response channel.
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [sfl_pkg::BLOCK_W-1:0]     o_block_out,
    output logic      [sfl_pkg::STATUS_W-1:0]    o_status,
    output logic      [sfl_pkg::COUNT_W-1:0]     o_bin_count,
    output logic      [sfl_pkg::SUM_W-1:0]       o_idle_total
);

    localparam int BIN_SEL_W = sfl_pkg::BIN_SEL_W;
    localparam int BLOCK_W   = sfl_pkg::BLOCK_W;
    localparam int COUNT_W   = sfl_pkg::COUNT_W;
    localparam int SUM_W     = sfl_pkg::SUM_W;
    localparam int SIZE_W    = sfl_pkg::SIZE_W;
    localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ADDR_W    = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);

    // Controller and response registers.
    sfl_pkg::t_state          r_state, n_state;
    logic [BIN_SEL_W-1:0]     r_bin, n_bin;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic                     r_out_valid, n_out_valid;
    logic [BLOCK_W-1:0]       r_block_out, n_block_out;
    sfl_pkg::t_status         r_status, n_status;
    logic [COUNT_W-1:0]       r_bin_count, n_bin_count;

    // Per-bin heads (no reset) and counts.
    logic [BLOCK_W-1:0]       r_head [NUM_BINS];
    logic [CNT_W-1:0]         r_count [NUM_BINS];

    // Bin table update controls.
    logic                     head_we;
    logic [BLOCK_W-1:0]       head_wdata;
    logic                     count_we;
    logic [CNT_W-1:0]         count_wdata;
    logic [BIN_W-1:0]         widx;

    // Link RAM port signals.
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [BLOCK_W-1:0]       ram_wdata;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [BLOCK_W-1:0]       ram_rdata;

    // Size lookup.
    sfl_pkg::t_cfg_wr         cfg_wr;
    logic [BIN_SEL_W-1:0]     size_sel;
    logic [SIZE_W-1:0]        size;

    // Datapath helpers.
    logic                     out_free;
    logic                     in_accept;
    logic                     bin_ok;
    logic                     blk_ok;
    logic [BIN_W-1:0]         bidx;
    logic [BIN_W-1:0]         qidx;
    logic [CNT_W-1:0]         cur_cnt;
    logic [BLOCK_W-1:0]       cur_head;
    logic [CNT_W-1:0]         cnt_inc;
    logic [CNT_W-1:0]         cnt_dec;
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_add_sat;
    logic [SUM_W-1:0]         sum_sub_sat;

    // Size register file.
    assign cfg_wr   = '{we: i_cfg_we, index: i_cfg_index, data: i_cfg_data};
    assign size_sel = (r_state == sfl_pkg::S_POP) ? r_bin : i_bin_sel;

    sfl_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cfg_wr),
        .i_rd_sel (size_sel),
        .o_size   (size)
    );

    // Next-link memory, one entry per block.
    sfl_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake on both channels.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == sfl_pkg::S_IDLE) && out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    // Bin lookups for the incoming request and for the pop in flight.
    assign bin_ok   = (32'(i_bin_sel) < NUM_BINS);
    assign blk_ok   = (32'(i_block_in) < NUM_BLOCKS);
    assign bidx     = BIN_W'(i_bin_sel);
    assign qidx     = BIN_W'(r_bin);
    assign cur_cnt  = r_count[bidx];
    assign cur_head = r_head[bidx];
    assign cnt_inc  = cur_cnt + CNT_W'(1);
    assign cnt_dec  = r_count[qidx] - CNT_W'(1);

    // Idle total with saturation at both ends.
    assign sum_add     = {1'b0, r_sum} + (SUM_W + 1)'(size);
    assign sum_add_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign sum_sub_sat = (r_sum < SUM_W'(size)) ? '0 : (r_sum - SUM_W'(size));

    // Controller: S_IDLE for most requests, a RAM read then update for a pop.
    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_out_ready;
        n_block_out = r_block_out;
        n_status    = r_status;
        n_bin_count = r_bin_count;
        head_we     = 1'b0;
        head_wdata  = i_block_in;
        count_we    = 1'b0;
        count_wdata = cnt_inc;
        widx        = bidx;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(i_block_in);
        ram_wdata   = cur_head;
        ram_re      = 1'b0;
        ram_raddr   = ADDR_W'(cur_head);

        case (r_state)
            sfl_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_bin       = i_bin_sel;
                    n_out_valid = 1'b1;
                    n_block_out = '0;
                    n_status    = sfl_pkg::ST_OK;
                    n_bin_count = '0;
                    if (!bin_ok) begin
                        n_status = (i_operation == sfl_pkg::OP_PUSH) ?
                                   sfl_pkg::ST_REJECT : sfl_pkg::ST_EMPTY;
                    end else if (i_operation == sfl_pkg::OP_PUSH) begin
                        if ((cur_cnt == CNT_W'(NUM_BLOCKS)) || !blk_ok) begin
                            n_status    = sfl_pkg::ST_REJECT;
                            n_bin_count = COUNT_W'(cur_cnt);
                        end else begin
                            // Link the block ahead of the head.
                            ram_we      = 1'b1;
                            head_we     = 1'b1;
                            count_we    = 1'b1;
                            n_sum       = sum_add_sat;
                            n_bin_count = COUNT_W'(cnt_inc);
                        end
                    end else if (cur_cnt == '0) begin
                        n_status = sfl_pkg::ST_EMPTY;
                    end else begin
                        // Fetch the head's next link; answer once it returns.
                        ram_re      = 1'b1;
                        n_out_valid = 1'b0;
                        n_state     = sfl_pkg::S_POP;
                    end
                end
            end
            sfl_pkg::S_POP: begin
                widx = qidx;
                if (out_free) begin
                    head_we     = 1'b1;
                    head_wdata  = ram_rdata;
                    count_we    = 1'b1;
                    count_wdata = cnt_dec;
                    n_sum       = sum_sub_sat;
                    n_out_valid = 1'b1;
                    n_block_out = r_head[qidx];
                    n_status    = sfl_pkg::ST_OK;
                    n_bin_count = COUNT_W'(cnt_dec);
                    n_state     = sfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sfl_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfl_pkg::S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bin       <= n_bin;
        r_block_out <= n_block_out;
        r_status    <= n_status;
        r_bin_count <= n_bin_count;
    end

    // Bin counts clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                r_count[i] <= '0;
            end
        end else if (count_we) begin
            r_count[widx] <= count_wdata;
        end
    end

    // Bin heads are only meaningful while the count is nonzero.
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head[widx] <= head_wdata;
        end
    end

    // Response outputs.
    assign o_out_valid  = r_out_valid;
    assign o_block_out  = r_block_out;
    assign o_status     = r_status;
    assign o_bin_count  = r_bin_count;
    assign o_idle_total = r_sum;

    // Checks on the controller.
    `SFL_ASSERT_NOW(a_no_take_in_pop, r_state == sfl_pkg::S_POP, !o_in_ready, "request taken during pop")
    `SFL_ASSERT_NEXT(a_pop_finishes, (r_state == sfl_pkg::S_POP) && out_free, (r_state == sfl_pkg::S_IDLE) && o_out_valid, "pop did not complete")
    `SFL_ASSERT_NOW(a_empty_no_block, o_out_valid && (o_status == sfl_pkg::ST_EMPTY), o_block_out == '0, "empty pop returned a block")
    `SFL_ASSERT_NOW(a_count_bound, o_out_valid, 32'(o_bin_count) <= NUM_BLOCKS, "bin count above capacity")

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for segregated_free_list: checks every response against a
// built-in model of the per-bin free lists, counts and idle byte total.
// Depends on sfl_pkg and the segregated_free_list RTL; reads no files.

module tb;

    localparam int OP_W      = sfl_pkg::OP_W;
    localparam int BIN_SEL_W = sfl_pkg::BIN_SEL_W;
    localparam int BLOCK_W   = sfl_pkg::BLOCK_W;
    localparam int STATUS_W  = sfl_pkg::STATUS_W;
    localparam int COUNT_W   = sfl_pkg::COUNT_W;
    localparam int SUM_W     = sfl_pkg::SUM_W;
    localparam int SIZE_W    = sfl_pkg::SIZE_W;
    localparam int REG_COUNT = sfl_pkg::REG_COUNT;
    localparam int REG_IDX_W = sfl_pkg::REG_IDX_W;

    localparam int                NUM_BINS   = sfl_pkg::NUM_BINS_DEF;
    localparam int                NUM_BLOCKS = sfl_pkg::NUM_BLOCKS_DEF;
    localparam logic [SUM_W:0]    SUM_MAX    = (1 << SUM_W) - 1;
    localparam logic [SIZE_W-1:0] SIZE_TOP   = '1;
    localparam int                LONG_HOLD  = 120;
    localparam int                FILL_BIN   = 5;
    localparam int                SPILL_BIN  = 2;

    // One expected response.
    typedef struct {
        logic [BLOCK_W-1:0] block;
        sfl_pkg::t_status   status;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   idle;
    } t_free_list_resp;

    // Block ports.
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [REG_IDX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_operation;
    logic [BIN_SEL_W-1:0] i_bin_sel;
    logic [BLOCK_W-1:0]   i_block_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BLOCK_W-1:0]   o_block_out;
    logic [STATUS_W-1:0]  o_status;
    logic [COUNT_W-1:0]   o_bin_count;
    logic [SUM_W-1:0]     o_idle_total;

    // Model state of the free lists.
    logic [BLOCK_W-1:0]   free_head  [NUM_BINS];
    logic [COUNT_W-1:0]   free_count [NUM_BINS];
    logic [BLOCK_W-1:0]   chain_link [NUM_BLOCKS];
    logic [SUM_W-1:0]     model_idle;
    logic [SIZE_W-1:0]    bin_bytes  [REG_COUNT];
    logic [SIZE_W-1:0]    next_sizes [REG_COUNT];
    bit                   block_listed [NUM_BLOCKS];
    int                   listed_total;

    t_free_list_resp      awaited_resp [$];
    int                   mismatch_count;
    int                   resp_count;
    int                   gap_cap;
    int                   stall_cap;
    int                   hold_requests;

    segregated_free_list dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_bin_sel    (i_bin_sel),
        .i_block_in   (i_block_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_block_out  (o_block_out),
        .o_status     (o_status),
        .o_bin_count  (o_bin_count),
        .o_idle_total (o_idle_total)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one accepted request to the model and return the response it owes.
    function automatic t_free_list_resp free_list_update(logic [OP_W-1:0] op,
                                                          logic [BIN_SEL_W-1:0] bin,
                                                          logic [BLOCK_W-1:0] blk);
        t_free_list_resp    resp;
        logic [SIZE_W-1:0]  size;
        logic [SUM_W:0]     wide;
        logic [BLOCK_W-1:0] top;
        resp.block  = '0;
        resp.status = sfl_pkg::ST_OK;
        size = bin_bytes[bin];
        if (op == sfl_pkg::OP_PUSH) begin
            if (free_count[bin] >= COUNT_W'(NUM_BLOCKS)) begin
                resp.status = sfl_pkg::ST_REJECT;
            end else begin
                chain_link[blk] = free_head[bin];
                free_head[bin]  = blk;
                free_count[bin] = free_count[bin] + 1'b1;
                block_listed[blk] = 1'b1;
                listed_total++;
                // The idle total saturates at the top of its range.
                wide = {1'b0, model_idle} + size;
                model_idle = (wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : wide[SUM_W-1:0];
            end
        end else if (free_count[bin] == '0) begin
            resp.status = sfl_pkg::ST_EMPTY;
        end else begin
            top = free_head[bin];
            resp.block      = top;
            free_head[bin]  = chain_link[top];
            free_count[bin] = free_count[bin] - 1'b1;
            block_listed[top] = 1'b0;
            listed_total--;
            // The idle total saturates at zero.
            model_idle = (model_idle < size) ? '0 : model_idle - size;
        end
        resp.count = free_count[bin];
        resp.idle  = model_idle;
        return resp;
    endfunction

    // Offer one request after a random gap and wait for its transfer.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [BIN_SEL_W-1:0] bin,
                                input logic [BLOCK_W-1:0] blk);
        int gap;
        gap = $urandom_range(0, gap_cap);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_bin_sel   <= bin;
        i_block_in  <= blk;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_resp.push_back(free_list_update(op, bin, blk));
    endtask

    // Pick a block that sits in no free list.
    function automatic logic [BLOCK_W-1:0] pick_spare();
        logic [BLOCK_W-1:0] blk;
        do blk = BLOCK_W'($urandom_range(0, NUM_BLOCKS - 1)); while (block_listed[blk]);
        return blk;
    endfunction

    // Mostly well-formed traffic: pushes of free-standing blocks and pops,
    // biased so the pool neither empties nor fills; empty pops are the noise.
    task automatic send_random_request();
        int pop_pct;
        logic [BIN_SEL_W-1:0] bin;
        bin = BIN_SEL_W'($urandom_range(0, NUM_BINS - 1));
        if (listed_total > 400)
            pop_pct = 75;
        else if (listed_total < 32)
            pop_pct = 30;
        else
            pop_pct = 50;
        if ($urandom_range(0, 99) < pop_pct)
            send_request(sfl_pkg::OP_POP, bin, BLOCK_W'($urandom));
        else
            send_request(sfl_pkg::OP_PUSH, bin, pick_spare());
    endtask

    // Lower valid and wait until every response has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_resp.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write all size registers from next_sizes; the block must be idle.
    task automatic program_sizes();
        for (int r = 0; r < REG_COUNT; r++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_IDX_W'(r);
            i_cfg_data  <= next_sizes[r];
            bin_bytes[r] = next_sizes[r];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all_sizes(input logic [SIZE_W-1:0] value);
        for (int r = 0; r < REG_COUNT; r++)
            next_sizes[r] = value;
    endtask

    // Pop every bin until the model says it is empty.
    task automatic drain_all();
        for (int b = 0; b < NUM_BINS; b++)
            while (free_count[b] != '0)
                send_request(sfl_pkg::OP_POP, BIN_SEL_W'(b), BLOCK_W'($urandom));
    endtask

    // Empty pops, a push to every bin, extreme block indices and LIFO order.
    task automatic test_directed();
        gap_cap   = 11;
        stall_cap = 11;
        send_request(sfl_pkg::OP_POP, 3'd0, 10'd0);
        send_request(sfl_pkg::OP_POP, 3'd7, 10'h3FF);
        for (int b = 0; b < NUM_BINS; b++)
            send_request(sfl_pkg::OP_PUSH, BIN_SEL_W'(b), BLOCK_W'(b * 100 + 7));
        send_request(sfl_pkg::OP_PUSH, 3'd0, 10'd0);
        send_request(sfl_pkg::OP_PUSH, 3'd0, 10'h3FF);
        repeat (4) send_request(sfl_pkg::OP_POP, 3'd0, 10'h3FF);
        for (int b = 1; b < NUM_BINS; b++)
            send_request(sfl_pkg::OP_POP, BIN_SEL_W'(b), 10'd0);
    endtask

    // Random traffic under several size settings, extremes among them.
    // Changing sizes while blocks are idle drives the total into saturation.
    task automatic test_size_settings();
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            for (int r = 0; r < REG_COUNT; r++) begin
                case (phase)
                    0: next_sizes[r] = SIZE_W'(1);
                    1: next_sizes[r] = SIZE_W'(65536);
                    2: next_sizes[r] = (r % 2 == 0) ? '0 : SIZE_TOP;
                    3: next_sizes[r] = SIZE_W'($urandom_range(1, 65536));
                    default: next_sizes[r] = SIZE_W'(16) << r;
                endcase
            end
            program_sizes();
            gap_cap   = (phase % 2 == 1) ? 0 : 11;
            stall_cap = (phase % 3 == 0) ? 0 : 11;
            repeat (120) send_random_request();
        end
    endtask

    // Back-pressure: a long receiver hold while the sender keeps offering,
    // then a sender pause until all is back, and runs without, then with stalls.
    task automatic test_back_pressure();
        gap_cap   = 11;
        stall_cap = 11;
        repeat (100) send_random_request();
        hold_requests++;
        gap_cap = 0;
        repeat (40) send_random_request();
        wait_drained();
        gap_cap   = 11;
        stall_cap = 0;
        repeat (80) send_random_request();
        stall_cap = 11;
        repeat (100) send_random_request();
    endtask

    // Fill one bin with every block, push once more into the full bin,
    // saturate the idle total at its top and then at zero.
    task automatic test_full_bin();
        int base;
        logic [BLOCK_W-1:0] moved;
        gap_cap   = 11;
        stall_cap = 11;
        drain_all();
        wait_drained();
        set_all_sizes(SIZE_TOP);
        program_sizes();
        gap_cap   = 0;
        stall_cap = 0;
        base = $urandom_range(0, NUM_BLOCKS - 1);
        for (int k = 0; k < NUM_BLOCKS; k++)
            send_request(sfl_pkg::OP_PUSH, BIN_SEL_W'(FILL_BIN),
                         BLOCK_W'((base + k) % NUM_BLOCKS));
        send_request(sfl_pkg::OP_PUSH, BIN_SEL_W'(FILL_BIN), BLOCK_W'($urandom));
        wait_drained();
        // A one-byte pop and a full-size push overflow the total.
        next_sizes[FILL_BIN] = SIZE_W'(1);
        program_sizes();
        moved = free_head[FILL_BIN];
        send_request(sfl_pkg::OP_POP, BIN_SEL_W'(FILL_BIN), 10'd0);
        send_request(sfl_pkg::OP_PUSH, BIN_SEL_W'(SPILL_BIN), moved);
        wait_drained();
        set_all_sizes(SIZE_TOP);
        program_sizes();
        gap_cap   = 11;
        stall_cap = 11;
        drain_all();
        // A block pushed at one byte and popped at full size floors the total.
        wait_drained();
        next_sizes[0] = SIZE_W'(1);
        program_sizes();
        send_request(sfl_pkg::OP_PUSH, 3'd0, pick_spare());
        wait_drained();
        next_sizes[0] = SIZE_TOP;
        program_sizes();
        send_request(sfl_pkg::OP_POP, 3'd0, 10'd0);
        send_request(sfl_pkg::OP_POP, 3'd0, 10'd0);
    endtask

    // Receiver: a random stall after each transfer, plus long holds on request.
    initial begin
        int stall_left;
        int hold_left;
        int resp_seen;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        resp_seen  = 0;
        hold_seen  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (resp_count != resp_seen) begin
                resp_seen  = resp_count;
                stall_left = $urandom_range(0, stall_cap);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string what, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each response transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_free_list_resp exp_resp;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            resp_count++;
            if (awaited_resp.size() == 0) begin
                $display("%0t: response with none expected, block %0d status %0d",
                         $time, o_block_out, o_status);
                mismatch_count++;
            end else begin
                exp_resp = awaited_resp.pop_front();
                check_field("block_out", SUM_W'(exp_resp.block), SUM_W'(o_block_out));
                check_field("status", SUM_W'(exp_resp.status), SUM_W'(o_status));
                check_field("bin_count", SUM_W'(exp_resp.count), SUM_W'(o_bin_count));
                check_field("idle_total", exp_resp.idle, o_idle_total);
            end
        end
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_operation   = sfl_pkg::OP_PUSH;
        i_bin_sel     = '0;
        i_block_in    = '0;
        i_out_ready   = 1'b0;
        mismatch_count = 0;
        resp_count    = 0;
        hold_requests = 0;
        gap_cap       = 0;
        stall_cap     = 0;
        listed_total  = 0;
        model_idle    = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            free_head[b]  = '0;
            free_count[b] = '0;
        end
        for (int r = 0; r < REG_COUNT; r++)
            bin_bytes[r] = SIZE_W'(16) << r;
        for (int k = 0; k < NUM_BLOCKS; k++) begin
            chain_link[k]   = '0;
            block_listed[k] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_size_settings();
        test_back_pressure();
        test_full_bin();
        wait_drained();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/sfl_pkg.sv
hdl/sfl_ram.sv
hdl/sfl_cfg.sv
hdl/segregated_free_list.sv
test/tb.sv
